// ----- sv/rrtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared constants for the round-robin task table: sizes, operation codes
// and status codes.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  // Table size and derived widths
  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths
  localparam int MODE_W   = 3;
  localparam int ID_W     = 16;
  localparam int NEXT_W   = ID_W + 1;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Slot entry in memory: {zombie, id}
  localparam int ENTRY_W = ID_W + 1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCHED  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REAP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NORUN    = 2'd3;

endpackage

// ----- sv/round_robin_task_table.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_table
// Task slot table with round-robin scheduling over running tasks.
//
// Usage: raise start with in_mode / in_task_id while busy is low; the item is
// taken at that edge and busy rises. Each operation sweeps every slot of the
// id/zombie memory once (one read a cycle, registered read data), folding
// the lookup, free-slot and next-runnable searches into that single pass; a
// final step writes the modified entry back and updates the scheduler state.
// The result is registered into the out_ ports by that final step and is
// marked by out_valid for exactly one cycle.
// No new item is taken while busy is high: the slot sweep through the single
// memory read port and the final step must finish first. A new item may be
// started in the cycle its predecessor's result is shown.
// The receiver cannot stall: a result must be taken in its strobe cycle.
// Reset (rst_n low, synchronous) empties the table at once through the
// per-slot valid flops, clears current task and id counter; no clearing
// pass is needed, so start is honoured in the first cycle after reset.
// ----------------------------------------------------------------------------
module round_robin_task_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrtt_pkg::MODE_W-1:0]   in_mode,
  input  logic [rrtt_pkg::ID_W-1:0]     in_task_id,
  output logic                          out_valid,
  output logic [rrtt_pkg::STATUS_W-1:0] out_status,
  output logic [rrtt_pkg::ID_W-1:0]     out_result_id,
  output logic [rrtt_pkg::COUNT_W-1:0]  out_reaped_count,
  output logic [rrtt_pkg::COUNT_W-1:0]  out_live_count
);

  import rrtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r;

  // Operation held for the sweep
  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0]   tid_r;

  // Scheduler state
  logic [MAX_TASKS-1:0] valid_r;
  logic [ID_W-1:0]      cur_id_r;
  logic                 has_cur_r;
  logic [NEXT_W-1:0]    next_id_r;
  logic [CNT_W-1:0]     live_r;

  // Sweep control
  logic [CNT_W-1:0] cnt_r;
  logic             proc_vld_r;
  logic [IDX_W-1:0] proc_idx_r;

  // Sweep accumulators
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             have_any_r;
  logic [ID_W-1:0]  best_any_r;
  logic             have_after_r;
  logic [ID_W-1:0]  best_after_r;
  logic [CNT_W-1:0] reaped_r;

  // Output registers
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_rid_r;
  logic [CNT_W-1:0]    out_reaped_r;

  // Memory ports
  logic               issue;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  assign issue = (state_r == S_SCAN) && (cnt_r != CNT_W'(MAX_TASKS));

  rrtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Per-entry evaluation of the slot returning from memory
  logic            pv;
  logic            pz;
  logic [ID_W-1:0] pid;
  logic [ID_W-1:0] match_id;
  logic            match_mode;
  logic            kill_mode;
  logic            match;
  logic            runnable;

  always_comb begin
    pv         = proc_vld_r && valid_r[proc_idx_r];
    pz         = ram_rdata[ENTRY_W-1];
    pid        = ram_rdata[ID_W-1:0];
    match_id   = (mode_r == MODE_EXIT) ? cur_id_r : tid_r;
    kill_mode  = (mode_r == MODE_STOP) || ((mode_r == MODE_EXIT) && has_cur_r);
    match_mode = kill_mode || (mode_r == MODE_LOOKUP);
    match      = pv && match_mode && (pid == match_id);
    runnable   = pv && !(pz || (match && kill_mode));
  end

  // Result of the operation, formed in the final cycle
  logic                fin_sched;
  logic [ID_W-1:0]     chosen;
  logic [STATUS_W-1:0] fin_status;
  logic [ID_W-1:0]     fin_rid;

  always_comb begin
    chosen     = have_after_r ? best_after_r : best_any_r;
    fin_sched  = 1'b0;
    fin_status = ST_OK;
    fin_rid    = '0;
    ram_we     = 1'b0;
    ram_waddr  = found_idx_r;
    ram_wdata  = {1'b1, match_id};
    unique case (mode_r)
      MODE_CREATE: begin
        if (!free_found_r || next_id_r[NEXT_W-1]) begin
          fin_status = ST_FULL;
        end else begin
          fin_rid   = next_id_r[ID_W-1:0];
          ram_we    = 1'b1;
          ram_waddr = free_idx_r;
          ram_wdata = {1'b0, next_id_r[ID_W-1:0]};
        end
      end
      MODE_STOP: begin
        if (!found_r) begin
          fin_status = ST_NOTFOUND;
        end else begin
          ram_we    = 1'b1;
          fin_sched = 1'b1;
        end
      end
      MODE_EXIT: begin
        if (!has_cur_r) begin
          fin_status = ST_NORUN;
        end else begin
          ram_we    = found_r;
          fin_sched = 1'b1;
        end
      end
      MODE_SCHED: begin
        fin_sched = 1'b1;
      end
      MODE_LOOKUP: begin
        if (found_r) begin
          fin_rid = tid_r;
        end else begin
          fin_status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    // Common scheduling step
    if (fin_sched) begin
      if (have_any_r) begin
        fin_rid = chosen;
      end else begin
        fin_status = ST_NORUN;
      end
    end
    ram_we = ram_we && (state_r == S_FIN);
  end

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cur_id_r    <= '0;
      has_cur_r   <= 1'b0;
      next_id_r   <= '0;
      live_r      <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      proc_vld_r  <= issue;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r == CNT_W'(MAX_TASKS)) begin
            state_r <= S_FIN;
          end
          // Reap clears valid flops as the sweep passes each zombie
          if ((mode_r == MODE_REAP) && pv && pz) begin
            valid_r[proc_idx_r] <= 1'b0;
          end
        end
        S_FIN: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if ((mode_r == MODE_CREATE) && (fin_status == ST_OK)) begin
            valid_r[free_idx_r] <= 1'b1;
            live_r              <= live_r + CNT_W'(1);
            next_id_r           <= next_id_r + NEXT_W'(1);
            if (!has_cur_r) begin
              cur_id_r  <= next_id_r[ID_W-1:0];
              has_cur_r <= 1'b1;
            end
          end
          if (mode_r == MODE_REAP) begin
            live_r <= live_r - reaped_r;
          end
          if (fin_sched && have_any_r) begin
            cur_id_r  <= chosen;
            has_cur_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Sweep counters, accumulators and operation capture
  always_ff @(posedge clk) begin
    proc_idx_r <= cnt_r[IDX_W-1:0];
    if ((state_r == S_IDLE) && start) begin
      mode_r       <= in_mode;
      tid_r        <= in_task_id;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      have_any_r   <= 1'b0;
      have_after_r <= 1'b0;
      reaped_r     <= '0;
    end else if (state_r == S_SCAN) begin
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (match && !found_r) begin
        found_r     <= 1'b1;
        found_idx_r <= proc_idx_r;
      end
      if (proc_vld_r && !valid_r[proc_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= proc_idx_r;
      end
      if (runnable && (!have_any_r || (pid < best_any_r))) begin
        have_any_r <= 1'b1;
        best_any_r <= pid;
      end
      if (runnable && has_cur_r && (pid > cur_id_r) &&
          (!have_after_r || (pid < best_after_r))) begin
        have_after_r <= 1'b1;
        best_after_r <= pid;
      end
      if ((mode_r == MODE_REAP) && pv && pz) begin
        reaped_r <= reaped_r + CNT_W'(1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      out_status_r <= fin_status;
      out_rid_r    <= fin_rid;
      out_reaped_r <= (mode_r == MODE_REAP) ? reaped_r : '0;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_id    = out_rid_r;
  assign out_reaped_count = COUNT_W'(out_reaped_r);
  assign out_live_count   = COUNT_W'(live_r);

endmodule

// ----- sv/rrtt_ram.sv -----
// ----------------------------------------------------------------------------
// rrtt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
